### hw/rtl/lrpie_pkg.sv
// shared types and constants for the partial lr35902 instruction executor
// no dependencies
package lrpie_pkg;

   localparam int ADDR_BITS = 16;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_EXEC  = 2'd2;

   localparam logic [15:0] PC_RESET = 16'h0100;
   localparam logic [15:0] SP_RESET = 16'hFFFE;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] LAST_VALID_OP = 8'h26;

   typedef struct packed {
      logic [15:0]     pc;
      logic [15:0]     sp;
      logic [7:0]      a;
      logic [3:0]      f;
      logic [5:0][7:0] gr;
   } regs_type;

   typedef struct packed {
      logic        wr;
      logic        wr2;
      logic        rd;
      logic [15:0] addr;
      logic [7:0]  data;
   } memop_type;

   localparam regs_type REGS_RESET = '{pc: PC_RESET, sp: SP_RESET, a: 8'h00, f: 4'h0,
                                       gr: '0};

endpackage

### hw/rtl/lrpie_channels.sv
// request and response channel interfaces of the instruction executor
// depends on nothing
interface lrpie_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] mem_address;
   logic [7:0]  mem_write_byte;
   modport source (output valid, req_type, mem_address, mem_write_byte, input ready);
   modport sink (input valid, req_type, mem_address, mem_write_byte, output ready);
endinterface

interface lrpie_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [4:0]  cycle_count;
   logic [7:0]  read_byte;
   logic [15:0] program_counter;
   logic [15:0] stack_pointer;
   logic [15:0] pair_af;
   logic [15:0] pair_bc;
   logic [15:0] pair_de;
   logic [15:0] pair_hl;
   modport source (output valid, status, cycle_count, read_byte, program_counter,
                   stack_pointer, pair_af, pair_bc, pair_de, pair_hl, input ready);
   modport sink (input valid, status, cycle_count, read_byte, program_counter,
                 stack_pointer, pair_af, pair_bc, pair_de, pair_hl, output ready);
endinterface

### hw/rtl/lr35902_partial_instruction_executor.sv
// Partial LR35902 core over a byte memory. A memory write goes to S_OUT right after acceptance,
// a memory read through S_RDW, an instruction through S_F1 to S_F3 and S_EX: three opcode bytes
// are fetched one per clock through the single-port synchronous memory, then S_EX executes;
// LD (a16),SP and LD A,(rr) add S_WR2 or S_LDA. One request is handled at a time. Memory
// contents are undefined until written; registers other than PC and SP reset to zero.
// top level; depends on lrpie_pkg, lrpie_channels and lrpie_alu
module lr35902_partial_instruction_executor (
   input  logic       clock,
   input  logic       reset,
   lrpie_req_if.sink  req_chan,
   lrpie_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE, S_RDW, S_F1, S_F2, S_F3, S_EX, S_WR2, S_LDA, S_OUT
   } state_type;

   state_type                state_ff, state_in;
   lrpie_pkg::regs_type      regs_ff, regs_in;
   lrpie_pkg::regs_type      alu_nxt;
   lrpie_pkg::memop_type     alu_mop;
   logic                     alu_status;
   logic [4:0]               alu_cycles;
   logic [7:0]               op_ff, b1_ff, b2_ff;
   logic                     status_ff;
   logic [4:0]               cyc_ff;
   logic [7:0]               rb_ff;
   logic [7:0]               mem [lrpie_pkg::MEM_DEPTH];
   logic [7:0]               mem_q_ff;
   logic [15:0]              mem_addr;
   logic [7:0]               mem_wdata;
   logic                     mem_we;
   logic                     accept;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   lrpie_alu u_alu (
      .op     (op_ff),
      .b1     (b1_ff),
      .b2     (b2_ff),
      .cur    (regs_ff),
      .nxt    (alu_nxt),
      .mop    (alu_mop),
      .status (alu_status),
      .cycles (alu_cycles)
   );

   always_comb begin
      mem_addr  = regs_ff.pc;
      mem_wdata = req_chan.mem_write_byte;
      mem_we    = 1'b0;
      state_in  = state_ff;
      regs_in   = regs_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.req_type)
                  lrpie_pkg::REQ_WRITE: begin
                     mem_addr = req_chan.mem_address;
                     mem_we   = 1'b1;
                     state_in = S_OUT;
                  end
                  lrpie_pkg::REQ_READ: begin
                     mem_addr = req_chan.mem_address;
                     state_in = S_RDW;
                  end
                  lrpie_pkg::REQ_EXEC: state_in = S_F1;
                  default:             state_in = S_OUT;
               endcase
            end
         end
         S_RDW: state_in = S_OUT;
         S_F1: begin
            mem_addr = regs_ff.pc + 16'd1;
            state_in = S_F2;
         end
         S_F2: begin
            mem_addr = regs_ff.pc + 16'd2;
            state_in = S_F3;
         end
         S_F3: state_in = S_EX;
         S_EX: begin
            regs_in   = alu_nxt;
            mem_addr  = alu_mop.addr;
            mem_wdata = alu_mop.data;
            mem_we    = alu_mop.wr;
            if (alu_mop.wr2) state_in = S_WR2;
            else if (alu_mop.rd) state_in = S_LDA;
            else state_in = S_OUT;
         end
         S_WR2: begin
            mem_addr  = {b2_ff, b1_ff} + 16'd1;
            mem_wdata = regs_ff.sp[15:8];
            mem_we    = 1'b1;
            state_in  = S_OUT;
         end
         S_LDA: begin
            regs_in.a = mem_q_ff;
            state_in  = S_OUT;
         end
         S_OUT: if (rsp_chan.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr[lrpie_pkg::ADDR_BITS-1:0]] <= mem_wdata;
      mem_q_ff <= mem[mem_addr[lrpie_pkg::ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         regs_ff   <= lrpie_pkg::REGS_RESET;
         status_ff <= 1'b0;
         cyc_ff    <= 5'd0;
         rb_ff     <= 8'd0;
      end else begin
         state_ff <= state_in;
         regs_ff  <= regs_in;
         if (accept) begin
            status_ff <= 1'b0;
            cyc_ff    <= 5'd0;
            rb_ff     <= 8'd0;
         end
         if (state_ff == S_RDW) rb_ff <= mem_q_ff;
         if (state_ff == S_EX) begin
            status_ff <= alu_status;
            cyc_ff    <= alu_cycles;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_F1) op_ff <= mem_q_ff;
      if (state_ff == S_F2) b1_ff <= mem_q_ff;
      if (state_ff == S_F3) b2_ff <= mem_q_ff;
   end

   assign rsp_chan.valid           = (state_ff == S_OUT);
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.cycle_count     = cyc_ff;
   assign rsp_chan.read_byte       = rb_ff;
   assign rsp_chan.program_counter = regs_ff.pc;
   assign rsp_chan.stack_pointer   = regs_ff.sp;
   assign rsp_chan.pair_af         = {regs_ff.a, regs_ff.f, 4'h0};
   assign rsp_chan.pair_bc         = {regs_ff.gr[0], regs_ff.gr[1]};
   assign rsp_chan.pair_de         = {regs_ff.gr[2], regs_ff.gr[3]};
   assign rsp_chan.pair_hl         = {regs_ff.gr[4], regs_ff.gr[5]};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request taken while busy");

   a_invalid_no_clocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |-> (rsp_chan.cycle_count == 5'd0))
      else $error("invalid opcode reports clocks");

   a_read_not_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.read_byte != 8'd0) |->
         (rsp_chan.cycle_count == 5'd0 && !rsp_chan.status))
      else $error("read byte on an instruction word");

   a_invalid_holds_pc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EX && alu_status) |=> $stable(regs_ff.pc))
      else $error("invalid opcode moved pc");

endmodule

### hw/rtl/lrpie_alu.sv
// decode and execute of one fetched opcode: next registers, memory action, clocks
// depends on lrpie_pkg
module lrpie_alu (
   input  logic [7:0]           op,
   input  logic [7:0]           b1,
   input  logic [7:0]           b2,
   input  lrpie_pkg::regs_type  cur,
   output lrpie_pkg::regs_type  nxt,
   output lrpie_pkg::memop_type mop,
   output logic                 status,
   output logic [4:0]           cycles
);

   logic [2:0]  r8;
   logic [2:0]  gidx;
   logic [1:0]  rp;
   logic [15:0] pair_v;
   logic [15:0] hl;
   logic [15:0] imm16;
   logic [7:0]  v8;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [15:0] step;
   logic [15:0] pair_inc;
   logic [15:0] pair_dec;

   always_comb begin
      r8       = op[5:3];
      gidx     = (r8 >= 3'd6) ? r8 - 3'd6 : r8;
      rp       = op[5:4];
      imm16    = {b2, b1};
      hl       = {cur.gr[4], cur.gr[5]};
      case (rp)
         2'd0:    pair_v = {cur.gr[0], cur.gr[1]};
         2'd1:    pair_v = {cur.gr[2], cur.gr[3]};
         default: pair_v = hl;
      endcase
      pair_inc = pair_v + 16'd1;
      pair_dec = pair_v - 16'd1;
      v8       = cur.gr[gidx];
      inc8     = v8 + 8'd1;
      dec8     = v8 - 8'd1;
      sum17    = {1'b0, hl} + {1'b0, pair_v};
      sum13    = {1'b0, hl[11:0]} + {1'b0, pair_v[11:0]};

      nxt    = cur;
      mop    = '0;
      status = 1'b0;
      cycles = 5'd4;
      step   = 16'd1;

      unique case (op) inside
         8'h00: ;
         8'h01, 8'h11, 8'h21: begin
            step = 16'd3;
            cycles = 5'd12;
            case (rp)
               2'd0:    {nxt.gr[0], nxt.gr[1]} = imm16;
               2'd1:    {nxt.gr[2], nxt.gr[3]} = imm16;
               default: {nxt.gr[4], nxt.gr[5]} = imm16;
            endcase
         end
         8'h02, 8'h12: begin
            cycles = 5'd8;
            mop.wr = 1'b1;
            mop.addr = pair_v;
            mop.data = cur.a;
         end
         8'h22: begin
            cycles = 5'd8;
            mop.wr = 1'b1;
            mop.addr = hl;
            mop.data = cur.a;
            {nxt.gr[4], nxt.gr[5]} = hl + 16'd1;
         end
         8'h03, 8'h13, 8'h23, 8'h0B, 8'h1B: begin
            cycles = 5'd8;
            case (rp)
               2'd0:    {nxt.gr[0], nxt.gr[1]} = op[3] ? pair_dec : pair_inc;
               2'd1:    {nxt.gr[2], nxt.gr[3]} = op[3] ? pair_dec : pair_inc;
               default: {nxt.gr[4], nxt.gr[5]} = op[3] ? pair_dec : pair_inc;
            endcase
         end
         8'h04, 8'h0C, 8'h14, 8'h1C, 8'h24: begin
            nxt.gr[gidx] = inc8;
            nxt.f = {inc8 == 8'h00, 1'b0, v8[3:0] == 4'hF, cur.f[lrpie_pkg::FLAG_C]};
         end
         8'h05, 8'h0D, 8'h15, 8'h1D, 8'h25: begin
            nxt.gr[gidx] = dec8;
            nxt.f = {v8 == 8'h01, 1'b1, v8[3:0] == 4'h0, cur.f[lrpie_pkg::FLAG_C]};
         end
         8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26: begin
            nxt.gr[gidx] = b1;
            step = 16'd2;
            cycles = 5'd8;
         end
         8'h07: begin
            nxt.a = {cur.a[6:0], cur.a[7]};
            nxt.f = {3'b000, cur.a[7]};
         end
         8'h0F: begin
            nxt.a = {cur.a[0], cur.a[7:1]};
            nxt.f = {3'b000, cur.a[0]};
         end
         8'h17: begin
            nxt.a = {cur.a[6:0], cur.f[lrpie_pkg::FLAG_C]};
            nxt.f = {3'b000, cur.a[7]};
         end
         8'h1F: begin
            nxt.a = {cur.f[lrpie_pkg::FLAG_C], cur.a[7:1]};
            nxt.f = {3'b000, cur.a[0]};
         end
         8'h08: begin
            step = 16'd3;
            cycles = 5'd20;
            mop.wr = 1'b1;
            mop.wr2 = 1'b1;
            mop.addr = imm16;
            mop.data = cur.sp[7:0];
         end
         8'h09, 8'h19: begin
            cycles = 5'd8;
            {nxt.gr[4], nxt.gr[5]} = sum17[15:0];
            nxt.f = {cur.f[lrpie_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
         end
         8'h0A, 8'h1A: begin
            cycles = 5'd8;
            mop.rd = 1'b1;
            mop.addr = pair_v;
         end
         8'h10: step = 16'd2;
         8'h18, 8'h20: begin
            step = 16'd2;
            cycles = 5'd8;
            if (!op[5] || !cur.f[lrpie_pkg::FLAG_Z]) begin
               step = 16'd2 + {{8{b1[7]}}, b1};
               cycles = 5'd12;
            end
         end
         default: begin
            status = 1'b1;
            cycles = 5'd0;
            step = 16'd0;
         end
      endcase
      nxt.pc = cur.pc + step;
   end

endmodule
